// ----- src/assert_macros.svh -----
// Assertion helpers, clocked on the rising edge and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold prop at every edge.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Require cons in the same cycle as ante.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Require cons in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/algr_pkg.sv -----
package algr_pkg;

  localparam int COORD_BITS = 6;
  localparam int FIELD_W    = 6;
  localparam int GLYPH_W    = 7;
  localparam int ERR_W      = COORD_BITS + 2;

  localparam logic [GLYPH_W-1:0] GLYPH_O      = 7'h4F;
  localparam logic [GLYPH_W-1:0] GLYPH_UNDER  = 7'h5F;
  localparam logic [GLYPH_W-1:0] GLYPH_DASH   = 7'h2D;
  localparam logic [GLYPH_W-1:0] GLYPH_DQUOTE = 7'h22;
  localparam logic [GLYPH_W-1:0] GLYPH_TICK   = 7'h60;
  localparam logic [GLYPH_W-1:0] GLYPH_BAR    = 7'h7C;
  localparam logic [GLYPH_W-1:0] GLYPH_BSLASH = 7'h5C;
  localparam logic [GLYPH_W-1:0] GLYPH_SLASH  = 7'h2F;

  typedef struct packed {
    logic [COORD_BITS-1:0]   col;
    logic [COORD_BITS-1:0]   row;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] adj;
  } step_t;

endpackage

// ----- src/algr_if.sv -----
interface algr_cmd_if;
  import algr_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] start_col;
  logic [FIELD_W-1:0] start_row;
  logic [FIELD_W-1:0] end_col;
  logic [FIELD_W-1:0] end_row;

  modport source (output valid, start_col, start_row, end_col, end_row, input ready);
  modport sink   (input valid, start_col, start_row, end_col, end_row, output ready);
endinterface

interface algr_wr_if;
  import algr_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] cell_col;
  logic [FIELD_W-1:0] cell_row;
  logic [GLYPH_W-1:0] glyph;
  logic               last_write;

  modport source (output valid, cell_col, cell_row, glyph, last_write, input ready);
  modport sink   (input valid, cell_col, cell_row, glyph, last_write, output ready);
endinterface

// ----- src/algr_step.sv -----
module algr_step (
  input  logic [algr_pkg::COORD_BITS-1:0]   col_i,
  input  logic [algr_pkg::COORD_BITS-1:0]   row_i,
  input  logic signed [algr_pkg::ERR_W-1:0] err_i,
  input  logic [algr_pkg::COORD_BITS-1:0]   dx_i,
  input  logic [algr_pkg::COORD_BITS-1:0]   dy_i,
  input  logic                              sx_i,
  input  logic                              sy_i,
  output algr_pkg::step_t                   step_o
);
  import algr_pkg::*;

  localparam int EW = ERR_W + 2;

  logic signed [EW-1:0] e2;
  logic signed [EW-1:0] dxe;
  logic signed [EW-1:0] dye;
  logic signed [EW-1:0] errn;
  logic signed [EW-1:0] adjn;

  always_comb begin
    e2   = EW'(err_i) <<< 1;
    dxe  = signed'(EW'(dx_i));
    dye  = signed'(EW'(dy_i));
    errn = EW'(err_i);
    adjn = EW'(err_i);
    step_o.col = col_i;
    step_o.row = row_i;
    if (e2 + dye >= 0) begin
      errn = errn - dye;
      step_o.col = sx_i ? col_i + 1'b1 : col_i - 1'b1;
    end else begin
      adjn = adjn + dye;
    end
    if (e2 <= dxe) begin
      errn = errn + dxe;
      step_o.row = sy_i ? row_i + 1'b1 : row_i - 1'b1;
    end else begin
      adjn = adjn - dxe;
    end
    step_o.err = ERR_W'(errn);
    step_o.adj = ERR_W'(adjn);
  end

endmodule

// ----- src/ascii_line_glyph_rasterizer.sv -----
// The first write (start 'O') is offered in S_START, after the SETUP and PRIME states that follow taking the command.
// Throughput: one write per cycle while the sink is ready; no new command is taken
// until the last write of a line has been accepted.
// The command port is ready only when the block is idle.
// Reset (async, active low) returns the sequencer to idle; no storage is cleared.
`include "assert_macros.svh"

module ascii_line_glyph_rasterizer (
  input  logic          clk_i,
  input  logic          rst_ni,
  algr_cmd_if.sink      cmd_i,
  algr_wr_if.source     wr_o
);
  import algr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_PRIME = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;
  localparam logic [2:0] S_GLYPH = 3'd5;

  localparam int VW = ERR_W + 6;
  localparam logic signed [VW-1:0] K_SCALE = VW'(56);
  localparam logic signed [VW-1:0] K_HI    = VW'(11);
  localparam logic signed [VW-1:0] K_MID   = VW'(3);

  logic [2:0] state_q, state_d;

  logic [COORD_BITS-1:0]   ac_q, ar_q, bc_q, br_q;
  logic [COORD_BITS-1:0]   dx_q, dy_q;
  logic                    sx_q, sy_q;
  logic signed [ERR_W-1:0] err_q;
  logic [COORD_BITS-1:0]   c0_q, r0_q, c1_q, r1_q, c2_q, r2_q;
  logic signed [ERR_W-1:0] a0_q, a1_q;

  step_t step;
  logic  end_hit;
  logic  advance;
  logic  wr_fire;

  logic [COORD_BITS-1:0] rd, cd, m_col;
  logic signed [VW-1:0]  span_s, v, th_hi, th_mid;
  logic [GLYPH_W-1:0]    glyph;

  algr_step u_step (
    .col_i  (c2_q),
    .row_i  (r2_q),
    .err_i  (err_q),
    .dx_i   (dx_q),
    .dy_i   (dy_q),
    .sx_i   (sx_q),
    .sy_i   (sy_q),
    .step_o (step)
  );

  assign end_hit = (c2_q == bc_q) && (r2_q == br_q);
  assign wr_fire = wr_o.valid && wr_o.ready;

  always_comb begin
    state_d = state_q;
    advance = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) state_d = S_SETUP;
      end
      S_SETUP: state_d = S_PRIME;
      S_PRIME: begin
        advance = !end_hit;
        state_d = S_START;
      end
      S_START: begin
        if (wr_o.ready) state_d = S_END;
      end
      S_END, S_GLYPH: begin
        if (wr_o.ready) begin
          advance = !end_hit;
          state_d = end_hit ? S_IDLE : S_GLYPH;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_i.valid) begin
      ac_q <= cmd_i.start_col[COORD_BITS-1:0];
      ar_q <= cmd_i.start_row[COORD_BITS-1:0];
      bc_q <= cmd_i.end_col[COORD_BITS-1:0];
      br_q <= cmd_i.end_row[COORD_BITS-1:0];
    end
    if (state_q == S_SETUP) begin
      sx_q  <= ac_q < bc_q;
      sy_q  <= ar_q < br_q;
      dx_q  <= (ac_q < bc_q) ? bc_q - ac_q : ac_q - bc_q;
      dy_q  <= (ar_q < br_q) ? br_q - ar_q : ar_q - br_q;
      err_q <= signed'(ERR_W'((ac_q < bc_q) ? bc_q - ac_q : ac_q - bc_q))
             - signed'(ERR_W'((ar_q < br_q) ? br_q - ar_q : ar_q - br_q));
      c2_q  <= ac_q;
      r2_q  <= ar_q;
    end
    if (advance) begin
      c0_q  <= c1_q;
      r0_q  <= r1_q;
      a0_q  <= a1_q;
      c1_q  <= c2_q;
      r1_q  <= r2_q;
      a1_q  <= step.adj;
      c2_q  <= step.col;
      r2_q  <= step.row;
      err_q <= step.err;
    end
  end

  always_comb begin
    rd     = (r0_q >= r2_q) ? r0_q - r2_q : r2_q - r0_q;
    cd     = (c0_q >= c2_q) ? c0_q - c2_q : c2_q - c0_q;
    m_col  = (r0_q < r2_q) ? c0_q : c2_q;
    span_s = signed'(VW'(dx_q) + VW'(dy_q));
    th_hi  = span_s * K_HI;
    th_mid = span_s * K_MID;
    v      = VW'(a0_q) * K_SCALE;
    if (!sy_q) v = -v;
    priority if (rd < COORD_BITS'(2)) begin
      priority if (v > th_hi)       glyph = GLYPH_TICK;
      else if (v > th_mid)          glyph = GLYPH_DQUOTE;
      else if (v > -th_hi)          glyph = GLYPH_DASH;
      else                          glyph = GLYPH_UNDER;
    end else if (cd < COORD_BITS'(2) && (c0_q >= c2_q || c1_q != c2_q)
                 && (c0_q <= c2_q || c1_q != c0_q)) begin
      glyph = GLYPH_BAR;
    end else if (m_col < c1_q) begin
      glyph = GLYPH_BSLASH;
    end else begin
      glyph = GLYPH_SLASH;
    end
  end

  assign cmd_i.ready = (state_q == S_IDLE);

  always_comb begin
    wr_o.valid      = 1'b0;
    wr_o.cell_col   = FIELD_W'(c1_q);
    wr_o.cell_row   = FIELD_W'(r1_q);
    wr_o.glyph      = glyph;
    wr_o.last_write = end_hit;
    unique case (state_q)
      S_START: begin
        wr_o.valid      = 1'b1;
        wr_o.cell_col   = FIELD_W'(ac_q);
        wr_o.cell_row   = FIELD_W'(ar_q);
        wr_o.glyph      = GLYPH_O;
        wr_o.last_write = 1'b0;
      end
      S_END: begin
        wr_o.valid      = 1'b1;
        wr_o.cell_col   = FIELD_W'(bc_q);
        wr_o.cell_row   = FIELD_W'(br_q);
        wr_o.glyph      = GLYPH_O;
      end
      S_GLYPH: wr_o.valid = 1'b1;
      default: wr_o.valid = 1'b0;
    endcase
  end

  `ASSERT_ALWAYS(a_no_overlap, clk_i, rst_ni, !(cmd_i.ready && wr_o.valid), "command taken while writing")
  `ASSERT_NEXT(a_last_idles, clk_i, rst_ni, wr_fire && wr_o.last_write, cmd_i.ready, "no idle after last word")
  `ASSERT_IMPLY(a_endpoint_o, clk_i, rst_ni, wr_o.valid && (state_q == S_START || state_q == S_END), wr_o.glyph == GLYPH_O, "endpoint not O")
  `ASSERT_IMPLY(a_start_not_last, clk_i, rst_ni, state_q == S_START, !wr_o.last_write, "start word flagged last")

endmodule
